[src/qph_pkg.sv]
// ---------------------------------------------------------------------------
// Quadratic probe hash insert: shared package
// Sizes, operation and status codes, beat types and the modular add used
// by the probe sequencer.
// ---------------------------------------------------------------------------
package qph_pkg;

   localparam int TABLE_DEPTH    = 64;
   localparam int KEY_BITS       = 16;
   localparam int ADDR_BITS      = $clog2(TABLE_DEPTH);
   localparam int KEY_FIELD_BITS = 16;
   localparam int CFG_BITS       = 7;
   localparam int SLOT_BITS      = 6;
   localparam int COUNT_BITS     = 8;
   localparam int OP_BITS        = 2;
   localparam int STATUS_BITS    = 2;
   localparam int CSR_INDEX_BITS = 1;
   localparam int DIV_COUNT_BITS = $clog2(KEY_BITS + 1);

   localparam logic [OP_BITS-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_BITS-1:0] OP_READ   = 2'd1;
   localparam logic [OP_BITS-1:0] OP_CLEAR  = 2'd2;

   localparam logic [STATUS_BITS-1:0] STATUS_DONE    = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_FULL    = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_ZERO    = 2'd2;
   localparam logic [STATUS_BITS-1:0] STATUS_BAD_CFG = 2'd3;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_HASH_DIVISOR = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TABLE_LENGTH = 1'd1;

   localparam logic [CFG_BITS-1:0] RESET_HASH_DIVISOR = 7'd13;
   localparam logic [CFG_BITS-1:0] RESET_TABLE_LENGTH = 7'd16;

   typedef struct packed {
      logic [OP_BITS-1:0]        operation;
      logic [KEY_FIELD_BITS-1:0] key;
      logic [SLOT_BITS-1:0]      slot_index;
   } req_type;

   typedef struct packed {
      logic [STATUS_BITS-1:0]    status;
      logic [SLOT_BITS-1:0]      placed_slot;
      logic [COUNT_BITS-1:0]     probe_count;
      logic [KEY_FIELD_BITS-1:0] slot_key;
   } rsp_type;

   typedef struct packed {
      logic                 done;
      logic [ADDR_BITS-1:0] remainder;
   } mod_stat_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_HASH,
      ST_PROBE,
      ST_READ,
      ST_RESP
   } state_type;

   // (a + b) mod m for a + b below twice m.
   function automatic logic [CFG_BITS-1:0] mod_add(input logic [CFG_BITS-1:0] a,
                                                   input logic [CFG_BITS-1:0] b,
                                                   input logic [CFG_BITS-1:0] m);
      logic [CFG_BITS:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      if (sum >= {1'b0, m}) begin
         sum = sum - {1'b0, m};
      end
      return sum[CFG_BITS-1:0];
   endfunction

endpackage

[src/qph_ram.sv]
// ---------------------------------------------------------------------------
// Generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module qph_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[src/qph_mod_unit.sv]
// ---------------------------------------------------------------------------
// Quadratic probe hash: remainder unit
// Restoring remainder of a key by the hash divisor, one key bit per cycle.
// ---------------------------------------------------------------------------
module qph_mod_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [qph_pkg::KEY_BITS-1:0]    dividend,
   input  logic [qph_pkg::CFG_BITS-1:0]    divisor,
   output qph_pkg::mod_stat_type           stat
);

   logic                                 busy_ff, busy_in;
   logic                                 done_ff, done_in;
   logic [qph_pkg::DIV_COUNT_BITS-1:0]   count_ff, count_in;
   logic [qph_pkg::KEY_BITS-1:0]         shift_ff, shift_in;
   logic [qph_pkg::ADDR_BITS-1:0]        rem_ff, rem_in;
   logic [qph_pkg::ADDR_BITS:0]          trial;

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      shift_in = shift_ff;
      rem_in   = rem_ff;
      trial    = {rem_ff, shift_ff[qph_pkg::KEY_BITS-1]};
      if (start) begin
         busy_in  = 1'b1;
         count_in = qph_pkg::DIV_COUNT_BITS'(qph_pkg::KEY_BITS);
         shift_in = dividend;
         rem_in   = '0;
      end else if (busy_ff) begin
         if (qph_pkg::CFG_BITS'(trial) >= divisor) begin
            rem_in = qph_pkg::ADDR_BITS'(qph_pkg::CFG_BITS'(trial) - divisor);
         end else begin
            rem_in = qph_pkg::ADDR_BITS'(trial);
         end
         shift_in = {shift_ff[qph_pkg::KEY_BITS-2:0], 1'b0};
         count_in = count_ff - 1'b1;
         if (count_ff == qph_pkg::DIV_COUNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
   end

   assign stat.done      = done_ff;
   assign stat.remainder = rem_ff;

endmodule

[src/quadratic_probe_hash_insert_unit.sv]
// ---------------------------------------------------------------------------
// Quadratic probe hash insert unit
// Open-addressing key table with quadratic probing, read and clear.
//
// Request beats on req_* carry an operation, a key and a slot index; each
// request gives exactly one response beat on rsp_*. The unit handles one
// request at a time and holds req_stall high until its response has been
// loaded into the output register. The hash divisor and table length must be
// written through csr_* only while no request is in flight; the unit does
// not enforce this. An insert first takes the key modulo the hash divisor
// in a bit-serial remainder unit, then checks one probe position per cycle
// against the slot occupancy flags. Reads pass through the registered table
// RAM, while clears and rejected inserts go straight to the response state.
// The next request can be accepted in the cycle after the response has been
// loaded. Reset empties the table at once and restores a divisor of 13
// and a table length of 16. While rsp_stall is high the response beat is
// held and the unit waits with its next response until the output
// register is free.
// ---------------------------------------------------------------------------
module quadratic_probe_hash_insert_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  qph_pkg::req_type                     req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output qph_pkg::rsp_type                     rsp_data,
   input  logic                                 csr_wr_en,
   input  logic [qph_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [qph_pkg::CFG_BITS-1:0]         csr_wr_data
);

   qph_pkg::state_type                   state_ff, state_in;
   qph_pkg::req_type                     req_ff, req_in;
   qph_pkg::rsp_type                     res_ff, res_in;
   qph_pkg::rsp_type                     rsp_ff, rsp_in;
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic [qph_pkg::CFG_BITS-1:0]         divisor_ff, divisor_in;
   logic [qph_pkg::CFG_BITS-1:0]         length_ff, length_in;
   logic [qph_pkg::TABLE_DEPTH-1:0]      occupied_ff, occupied_in;
   logic [qph_pkg::CFG_BITS-1:0]         home_ff, home_in;
   logic [qph_pkg::CFG_BITS-1:0]         pos_ff, pos_in;
   logic [qph_pkg::CFG_BITS-1:0]         square_ff, square_in;
   logic [qph_pkg::CFG_BITS-1:0]         odd_ff, odd_in;
   logic [qph_pkg::CFG_BITS-1:0]         iter_ff, iter_in;
   logic                                 upward_ff, upward_in;
   logic [qph_pkg::COUNT_BITS-1:0]       count_ff, count_in;

   logic                                 accept;
   logic                                 out_free;
   logic                                 zero_key;
   logic                                 bad_cfg;
   logic                                 slot_taken;
   logic                                 last_round;
   logic                                 read_in_range;
   logic [qph_pkg::CFG_BITS-1:0]         square_next;
   logic                                 mod_start;
   qph_pkg::mod_stat_type                mod_stat;
   logic                                 ram_wr_en;
   logic [qph_pkg::ADDR_BITS-1:0]        ram_wr_addr;
   logic [qph_pkg::ADDR_BITS-1:0]        ram_rd_addr;
   logic [qph_pkg::KEY_BITS-1:0]         ram_rd_data;
   logic [qph_pkg::KEY_BITS-1:0]         key_masked;

   assign accept        = req_valid && !req_stall;
   assign out_free      = !rsp_valid_ff || !rsp_stall;
   assign key_masked    = qph_pkg::KEY_BITS'(req_data.key);
   assign zero_key      = (key_masked == '0);
   assign bad_cfg       = (divisor_ff == '0) || (length_ff == '0)
                          || (32'(length_ff) > qph_pkg::TABLE_DEPTH)
                          || (divisor_ff > length_ff);
   assign slot_taken    = occupied_ff[pos_ff[qph_pkg::ADDR_BITS-1:0]];
   assign last_round    = (iter_ff == length_ff);
   assign read_in_range = (32'(req_ff.slot_index) < qph_pkg::TABLE_DEPTH);
   assign square_next   = qph_pkg::mod_add(square_ff, odd_ff, length_ff);
   assign mod_start     = accept && (req_data.operation == qph_pkg::OP_INSERT)
                          && !zero_key && !bad_cfg;
   assign ram_rd_addr   = qph_pkg::ADDR_BITS'(req_data.slot_index);
   assign ram_wr_addr   = pos_ff[qph_pkg::ADDR_BITS-1:0];
   assign req_stall     = (state_ff != qph_pkg::ST_IDLE);

   qph_mod_unit u_mod (
      .clock    (clock),
      .reset    (reset),
      .start    (mod_start),
      .dividend (key_masked),
      .divisor  (divisor_ff),
      .stat     (mod_stat)
   );

   qph_ram #(
      .WIDTH (qph_pkg::KEY_BITS),
      .DEPTH (qph_pkg::TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (req_ff.key[qph_pkg::KEY_BITS-1:0]),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         qph_pkg::ST_IDLE: begin
            if (accept) begin
               if (mod_start) begin
                  state_in = qph_pkg::ST_HASH;
               end else if (req_data.operation == qph_pkg::OP_READ) begin
                  state_in = qph_pkg::ST_READ;
               end else begin
                  state_in = qph_pkg::ST_RESP;
               end
            end
         end
         qph_pkg::ST_HASH: begin
            if (mod_stat.done) begin
               state_in = qph_pkg::ST_PROBE;
            end
         end
         qph_pkg::ST_PROBE: begin
            if (!slot_taken || (!upward_ff && last_round)) begin
               state_in = qph_pkg::ST_RESP;
            end
         end
         qph_pkg::ST_READ: begin
            state_in = qph_pkg::ST_RESP;
         end
         qph_pkg::ST_RESP: begin
            if (out_free) begin
               state_in = qph_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = qph_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_in       = req_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      divisor_in   = divisor_ff;
      length_in    = length_ff;
      occupied_in  = occupied_ff;
      home_in      = home_ff;
      pos_in       = pos_ff;
      square_in    = square_ff;
      odd_in       = odd_ff;
      iter_in      = iter_ff;
      upward_in    = upward_ff;
      count_in     = count_ff;
      ram_wr_en    = 1'b0;

      if (csr_wr_en) begin
         unique case (csr_index)
            qph_pkg::CSR_HASH_DIVISOR: divisor_in = csr_wr_data;
            qph_pkg::CSR_TABLE_LENGTH: length_in  = csr_wr_data;
            default: ;
         endcase
      end

      unique case (state_ff)
         qph_pkg::ST_IDLE: begin
            if (accept) begin
               req_in = req_data;
               res_in = '0;
               res_in.status = qph_pkg::STATUS_DONE;
               if (req_data.operation == qph_pkg::OP_INSERT) begin
                  if (zero_key) begin
                     res_in.status = qph_pkg::STATUS_ZERO;
                  end else if (bad_cfg) begin
                     res_in.status = qph_pkg::STATUS_BAD_CFG;
                  end
               end else if (req_data.operation == qph_pkg::OP_CLEAR) begin
                  occupied_in = '0;
               end
            end
         end
         qph_pkg::ST_HASH: begin
            home_in   = qph_pkg::CFG_BITS'(mod_stat.remainder);
            pos_in    = qph_pkg::CFG_BITS'(mod_stat.remainder);
            square_in = '0;
            odd_in    = (length_ff == qph_pkg::CFG_BITS'(1)) ? '0 : qph_pkg::CFG_BITS'(1);
            iter_in   = '0;
            upward_in = 1'b0;
            count_in  = '0;
         end
         qph_pkg::ST_PROBE: begin
            if (!slot_taken) begin
               ram_wr_en = 1'b1;
               occupied_in[pos_ff[qph_pkg::ADDR_BITS-1:0]] = 1'b1;
               res_in.status      = qph_pkg::STATUS_DONE;
               res_in.placed_slot = qph_pkg::SLOT_BITS'(pos_ff);
               res_in.probe_count = count_ff;
               res_in.slot_key    = '0;
            end else begin
               count_in = count_ff + 1'b1;
               if (upward_ff) begin
                  pos_in    = qph_pkg::mod_add(home_ff, length_ff - square_ff, length_ff);
                  upward_in = 1'b0;
               end else if (last_round) begin
                  res_in        = '0;
                  res_in.status = qph_pkg::STATUS_FULL;
               end else begin
                  iter_in   = iter_ff + 1'b1;
                  square_in = square_next;
                  odd_in    = qph_pkg::mod_add(odd_ff, qph_pkg::CFG_BITS'(2), length_ff);
                  pos_in    = qph_pkg::mod_add(home_ff, square_next, length_ff);
                  upward_in = 1'b1;
               end
            end
         end
         qph_pkg::ST_READ: begin
            if (read_in_range
                && occupied_ff[qph_pkg::ADDR_BITS'(req_ff.slot_index)]) begin
               res_in.slot_key = qph_pkg::KEY_FIELD_BITS'(ram_rd_data);
            end else begin
               res_in.slot_key = '0;
            end
         end
         qph_pkg::ST_RESP: begin
            if (out_free) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= qph_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         divisor_ff   <= qph_pkg::RESET_HASH_DIVISOR;
         length_ff    <= qph_pkg::RESET_TABLE_LENGTH;
         occupied_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         divisor_ff   <= divisor_in;
         length_ff    <= length_in;
         occupied_ff  <= occupied_in;
      end
      req_ff    <= req_in;
      res_ff    <= res_in;
      rsp_ff    <= rsp_in;
      home_ff   <= home_in;
      pos_ff    <= pos_in;
      square_ff <= square_in;
      odd_ff    <= odd_in;
      iter_ff   <= iter_in;
      upward_ff <= upward_in;
      count_ff  <= count_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
